>>> src/aabb_frustum_cull_assert.svh
// assertion macros for the frustum cull block
// used by the checker, no other dependencies
`ifndef AABB_FRUSTUM_CULL_ASSERT_SVH
`define AABB_FRUSTUM_CULL_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define AFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum cull check failed");

// next-cycle implication, checked in every cycle
`define AFC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("frustum cull check failed");

`endif

>>> src/afc_pkg.sv
// shared constants and types for the frustum cull block
// no dependencies
`default_nettype none

package afc_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 16;
   localparam int COORD_FRAC      = 16;
   localparam int NUM_PLANES      = 6;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PLANE_LEFT   = 3'd0,
      CSR_PLANE_RIGHT  = 3'd1,
      CSR_PLANE_BOTTOM = 3'd2,
      CSR_PLANE_TOP    = 3'd3,
      CSR_PLANE_NEAR   = 3'd4,
      CSR_PLANE_FAR    = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

>>> src/afc_plane_regs.sv
// plane register file, six packed planes written through the csr port
// depends on afc_pkg
`default_nettype none

module afc_plane_regs
   import afc_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_en,
   input  logic [CSR_INDEX_W-1:0]                    csr_index,
   input  logic [CSR_DATA_W-1:0]                     csr_wdata,
   output logic [NUM_PLANES-1:0][4*COEF_WIDTH-1:0]   planes
);

   localparam int PLANE_W = 4 * COEF_WIDTH;

   logic [NUM_PLANES-1:0][PLANE_W-1:0] planes_ff;
   logic                               index_ok;

   assign index_ok = (csr_index <= CSR_PLANE_FAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else if (csr_write_en && index_ok) begin
         planes_ff[csr_index] <= csr_wdata[PLANE_W-1:0];
      end
   end

   assign planes = planes_ff;

endmodule

`default_nettype wire

>>> src/afc_plane_lane.sv
// one plane test: positive corner select, products, exact sum and sign
// depends on afc_pkg
`default_nettype none

module afc_plane_lane
   import afc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic [4*COEF_WIDTH-1:0]     plane,
   input  logic [2:0][COORD_WIDTH-1:0] box_min,
   input  logic [2:0][COORD_WIDTH-1:0] box_max,
   output logic                        pass
);

   localparam int PROD_W  = COORD_WIDTH + COEF_WIDTH;
   localparam int D_SHIFT = COORD_FRAC + COEF_WIDTH - 4;
   localparam int DTERM_W = COEF_WIDTH + D_SHIFT;
   localparam int SUM_W   = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;

   logic signed [COEF_WIDTH-1:0]  coef [3];
   logic signed [COORD_WIDTH-1:0] corner [3];
   logic signed [PROD_W-1:0]      prod_in [3];
   logic signed [PROD_W-1:0]      prod_ff [3];
   logic signed [COEF_WIDTH-1:0]  d_ff;
   logic signed [DTERM_W-1:0]     dterm;
   logic signed [SUM_W-1:0]       sum;

   for (genvar k = 0; k < 3; k++) begin : g_axis
      assign coef[k]    = $signed(plane[k*COEF_WIDTH +: COEF_WIDTH]);
      assign corner[k]  = coef[k][COEF_WIDTH-1] ? $signed(box_min[k]) : $signed(box_max[k]);
      assign prod_in[k] = PROD_W'(coef[k]) * PROD_W'(corner[k]);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      d_ff    <= $signed(plane[3*COEF_WIDTH +: COEF_WIDTH]);
   end

   assign dterm = $signed({d_ff, {D_SHIFT{1'b0}}});

   always_comb begin
      sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]) + SUM_W'(dterm);
   end

   assign pass = ~sum[SUM_W-1];

endmodule

`default_nettype wire

>>> src/aabb_frustum_cull.sv
// frustum cull top level: request register, plane registers, six plane lanes,
// result register; depends on afc_pkg, afc_plane_regs and afc_plane_lane
//
// usage
//   software loads the six plane registers through csr_write_en, csr_index
//   and csr_wdata; a write takes effect at the clock edge, writes to index
//   six and seven are dropped; the user must write planes only while no
//   request is in flight, the block itself does not enforce this
//   a request is taken at each clock edge where start is high and busy is
//   low; busy is low at all times outside reset, so one box per cycle
//   the result shows on rsp_keep with rsp_valid high for one cycle, in
//   request order, after passing the request register, the product
//   register of the eighteen multipliers and the result register
//   the receiver cannot stall the block and needs no back-pressure
//   reset clears the planes to zero, which keeps every drawable item, and
//   drops any request still in the pipeline
`default_nettype none

module aabb_frustum_cull
   import afc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_drawable,
   input  logic                          req_has_bounds,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_z,
   output logic                          rsp_valid,
   output logic                          rsp_keep,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   logic [NUM_PLANES-1:0][4*COEF_WIDTH-1:0] planes;
   logic [NUM_PLANES-1:0]                   pass;

   logic                        accept;
   logic                        s1_valid_ff;
   logic                        s1_drawable_ff;
   logic                        s1_has_bounds_ff;
   logic [2:0][COORD_WIDTH-1:0] s1_box_min_ff;
   logic [2:0][COORD_WIDTH-1:0] s1_box_max_ff;
   logic                        s2_valid_ff;
   logic                        s2_drawable_ff;
   logic                        s2_has_bounds_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_keep_ff;
   logic                        rsp_keep_in;

   assign busy   = reset;
   assign accept = start && !busy;

   afc_plane_regs #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .planes       (planes)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_drawable_ff   <= req_drawable;
      s1_has_bounds_ff <= req_has_bounds;
      s1_box_min_ff    <= {req_box_min_z, req_box_min_y, req_box_min_x};
      s1_box_max_ff    <= {req_box_max_z, req_box_max_y, req_box_max_x};
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
      afc_plane_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .COEF_WIDTH  (COEF_WIDTH)
      ) u_lane (
         .clock   (clock),
         .plane   (planes[p]),
         .box_min (s1_box_min_ff),
         .box_max (s1_box_max_ff),
         .pass    (pass[p])
      );
   end

   // flags follow the product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_drawable_ff   <= s1_drawable_ff;
      s2_has_bounds_ff <= s1_has_bounds_ff;
   end

   assign rsp_keep_in = s2_drawable_ff && (!s2_has_bounds_ff || (&pass));

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_keep_ff <= rsp_keep_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_keep  = rsp_keep_ff;

endmodule

`default_nettype wire

>>> src/afc_checker.sv
// port-level checks for the frustum cull block, bound to the top level
// depends on aabb_frustum_cull_assert.svh
`default_nettype none

`include "aabb_frustum_cull_assert.svh"

module afc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_drawable,
   input logic req_has_bounds,
   input logic rsp_valid,
   input logic rsp_keep
);

   `AFC_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)
   `AFC_ASSERT_IMPLY(a_req_to_rsp, clock, reset, start && !busy, ##3 rsp_valid)
   `AFC_ASSERT_IMPLY(a_rsp_from_req, clock, reset, rsp_valid, $past(start && !busy, 3))
   `AFC_ASSERT_IMPLY(a_keep_drawable, clock, reset, rsp_valid && rsp_keep, $past(req_drawable, 3))
   `AFC_ASSERT_IMPLY(a_unbounded_keep, clock, reset, rsp_valid && !$past(req_has_bounds, 3), rsp_keep == $past(req_drawable, 3))

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_drawable   (req_drawable),
   .req_has_bounds (req_has_bounds),
   .rsp_valid      (rsp_valid),
   .rsp_keep       (rsp_keep)
);

`default_nettype wire
